[hdl/assert_macros.svh]
// assertion macros used by the scheduler engine rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// next-cycle implication
`define VS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

[hdl/vswfq_pkg.sv]
// types, constants and helpers of the virtual spacing wfq scheduler
// no dependencies
package vswfq_pkg;

   localparam int NUM_VC      = 16;
   localparam int QUEUE_DEPTH = 16;

   localparam int VC_W    = $clog2(NUM_VC);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int LEN_W   = $clog2(NUM_VC + 1);
   localparam int CELL_AW = $clog2(NUM_VC * QUEUE_DEPTH);

   localparam int CMD_W     = 2;
   localparam int VCID_W    = 8;
   localparam int TAG_W     = 16;
   localparam int DELTA_W   = 16;
   localparam int BLIM_W    = 5;
   localparam int STATUS_W  = 3;
   localparam int SENT_VC_W = 4;
   localparam int QLEN_W    = 5;
   localparam int TIME_W    = 32;
   localparam int LIMIT_W   = 31;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);

   localparam logic [CMD_W-1:0] CMD_ARRIVAL  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNREG     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_REG   = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic               vc_ok;
      logic [VC_W-1:0]    vc;
      logic [TAG_W-1:0]   payload;
      logic [DELTA_W-1:0] delta;
      logic [BLIM_W-1:0]  buffer_limit;
      logic               param_bad;
   } item_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [CELL_AW-1:0] cell_addr(input logic [VC_W-1:0] v,
                                                    input logic [PTR_W-1:0] p);
      return CELL_AW'(v) * CELL_AW'(QUEUE_DEPTH) + CELL_AW'(p);
   endfunction

endpackage

[hdl/vswfq_front.sv]
// front end: accepts request transactions and classifies them
// depends on vswfq_pkg
module vswfq_front (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [vswfq_pkg::CMD_W-1:0]   req_command,
   input  logic [vswfq_pkg::VCID_W-1:0]  req_vc,
   input  logic [vswfq_pkg::TAG_W-1:0]   req_payload,
   input  logic [vswfq_pkg::DELTA_W-1:0] req_delta,
   input  logic [vswfq_pkg::BLIM_W-1:0]  req_buffer_limit,
   input  logic                         q_full,
   output logic                         q_push,
   output vswfq_pkg::item_type          q_push_item
);
   import vswfq_pkg::*;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_push_item.command      = req_command;
      q_push_item.vc_ok        = (req_vc < VCID_W'(NUM_VC));
      q_push_item.vc           = req_vc[VC_W-1:0];
      q_push_item.payload      = req_payload;
      q_push_item.delta        = req_delta;
      q_push_item.buffer_limit = req_buffer_limit;
      q_push_item.param_bad    = (req_delta == '0) || (req_buffer_limit == '0) ||
                                 (req_buffer_limit > BLIM_W'(QUEUE_DEPTH));
   end

endmodule

[hdl/vswfq_queue.sv]
// two-entry queue between the front end and the scheduler engine
// depends on vswfq_pkg
module vswfq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vswfq_pkg::item_type push_item,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop,
   output vswfq_pkg::item_type pop_item
);
   import vswfq_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full      = (fill_ff == 2'd2);
   assign pop_valid = (fill_ff != 2'd0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/vswfq_back.sv]
// scheduler engine: connection tables, cell memory, ordered list, result register
// depends on vswfq_pkg and assert_macros.svh
`include "assert_macros.svh"
module vswfq_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  vswfq_pkg::item_type             q_item,
   output logic                            q_pop,
   input  logic                            csr_wr_en,
   input  logic [vswfq_pkg::LIMIT_W-1:0]    csr_wr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [vswfq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [vswfq_pkg::SENT_VC_W-1:0]  rsp_sent_vc,
   output logic [vswfq_pkg::TAG_W-1:0]      rsp_sent_payload,
   output logic [vswfq_pkg::QLEN_W-1:0]     rsp_queue_length,
   output logic [vswfq_pkg::TIME_W-1:0]     rsp_spacing_time
);
   import vswfq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_REBASE = 3'd3;
   localparam logic [2:0] S_SEEK   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [TIME_W-1:0]  vt_ff, vt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   item_type           item_ff, item_in;
   logic [VC_W-1:0]    ins_vc_ff, ins_vc_in;
   logic [TIME_W-1:0]  new_stamp_ff, new_stamp_in;

   logic               registered_ff [NUM_VC];
   logic               registered_in [NUM_VC];
   logic [CNT_W-1:0]   count_ff [NUM_VC];
   logic [CNT_W-1:0]   count_in [NUM_VC];
   logic [PTR_W-1:0]   head_ff [NUM_VC];
   logic [PTR_W-1:0]   head_in [NUM_VC];
   logic [PTR_W-1:0]   tail_ff [NUM_VC];
   logic [PTR_W-1:0]   tail_in [NUM_VC];
   logic [DELTA_W-1:0] spacing_ff [NUM_VC];
   logic [DELTA_W-1:0] spacing_in [NUM_VC];
   logic [CNT_W-1:0]   capacity_ff [NUM_VC];
   logic [CNT_W-1:0]   capacity_in [NUM_VC];
   logic [VC_W-1:0]    list_vc_ff [NUM_VC];
   logic [VC_W-1:0]    list_vc_in [NUM_VC];
   logic [TIME_W-1:0]  list_stamp_ff [NUM_VC];
   logic [TIME_W-1:0]  list_stamp_in [NUM_VC];

   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [SENT_VC_W-1:0] res_vc_ff, res_vc_in;
   logic [TAG_W-1:0]     res_payload_ff, res_payload_in;
   logic [CNT_W-1:0]     res_qlen_ff, res_qlen_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SENT_VC_W-1:0] rsp_vc_ff, rsp_vc_in;
   logic [TAG_W-1:0]     rsp_payload_ff, rsp_payload_in;
   logic [CNT_W-1:0]     rsp_qlen_ff, rsp_qlen_in;
   logic [TIME_W-1:0]    rsp_time_ff, rsp_time_in;

   logic [TAG_W-1:0]   cell_mem [NUM_VC*QUEUE_DEPTH];
   logic [TAG_W-1:0]   cell_rd_ff;
   logic               cell_we, cell_re;
   logic [CELL_AW-1:0] cell_waddr, cell_raddr;

   logic [VC_W-1:0]    cur;
   logic [VC_W-1:0]    idx;
   logic [VC_W-1:0]    head_vc;
   logic [TIME_W-1:0]  idx_stamp;

   assign cur       = item_ff.vc;
   assign idx       = pos_ff[VC_W-1:0];
   assign head_vc   = list_vc_ff[0];
   assign idx_stamp = list_stamp_ff[idx];

   always_comb begin
      state_in       = state_ff;
      limit_in       = limit_ff;
      vt_in          = vt_ff;
      len_in         = len_ff;
      pos_in         = pos_ff;
      item_in        = item_ff;
      ins_vc_in      = ins_vc_ff;
      new_stamp_in   = new_stamp_ff;
      registered_in  = registered_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      spacing_in     = spacing_ff;
      capacity_in    = capacity_ff;
      list_vc_in     = list_vc_ff;
      list_stamp_in  = list_stamp_ff;
      res_status_in  = res_status_ff;
      res_vc_in      = res_vc_ff;
      res_payload_in = res_payload_ff;
      res_qlen_in    = res_qlen_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_vc_in      = rsp_vc_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_qlen_in    = rsp_qlen_ff;
      rsp_time_in    = rsp_time_ff;
      q_pop          = 1'b0;
      cell_we        = 1'b0;
      cell_re        = 1'b0;
      cell_waddr     = '0;
      cell_raddr     = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in  = ST_OK;
            res_vc_in      = '0;
            res_payload_in = '0;
            res_qlen_in    = '0;
            state_in       = S_DONE;
            case (item_ff.command)
               CMD_ARRIVAL: begin
                  if (!item_ff.vc_ok) begin
                     res_status_in = ST_INVALID;
                  end else if (!registered_ff[cur]) begin
                     res_status_in = ST_UNREG;
                  end else if ((count_ff[cur] >= capacity_ff[cur]) ||
                               (count_ff[cur] >= CNT_W'(QUEUE_DEPTH))) begin
                     res_status_in = ST_DROPPED;
                     res_qlen_in   = count_ff[cur];
                  end else begin
                     cell_we       = 1'b1;
                     cell_waddr    = cell_addr(cur, tail_ff[cur]);
                     tail_in[cur]  = ptr_next(tail_ff[cur]);
                     count_in[cur] = count_ff[cur] + 1'b1;
                     res_qlen_in   = count_ff[cur] + 1'b1;
                     if (count_ff[cur] == '0) begin
                        new_stamp_in = vt_ff + TIME_W'(spacing_ff[cur]);
                        ins_vc_in    = cur;
                        pos_in       = '0;
                        state_in     = S_SEEK;
                     end
                  end
               end
               CMD_TICK: begin
                  if (len_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     for (int i = 0; i < NUM_VC - 1; i++) begin
                        list_vc_in[i]    = list_vc_ff[i+1];
                        list_stamp_in[i] = list_stamp_ff[i+1];
                     end
                     len_in            = len_ff - 1'b1;
                     vt_in             = list_stamp_ff[0];
                     cell_re           = 1'b1;
                     cell_raddr        = cell_addr(head_vc, head_ff[head_vc]);
                     head_in[head_vc]  = ptr_next(head_ff[head_vc]);
                     count_in[head_vc] = count_ff[head_vc] - 1'b1;
                     res_qlen_in       = count_ff[head_vc] - 1'b1;
                     res_vc_in         = SENT_VC_W'(head_vc);
                     ins_vc_in         = head_vc;
                     state_in          = S_READ;
                  end
               end
               CMD_REGISTER: begin
                  if (!item_ff.vc_ok) begin
                     res_status_in = ST_INVALID;
                  end else if (registered_ff[cur] || item_ff.param_bad) begin
                     res_status_in = ST_BAD_REG;
                     res_qlen_in   = count_ff[cur];
                  end else begin
                     registered_in[cur] = 1'b1;
                     spacing_in[cur]    = item_ff.delta;
                     capacity_in[cur]   = CNT_W'(item_ff.buffer_limit);
                     count_in[cur]      = '0;
                     head_in[cur]       = '0;
                     tail_in[cur]       = '0;
                  end
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_READ: begin
            res_payload_in = cell_rd_ff;
            pos_in         = '0;
            if (vt_ff > {1'b0, limit_ff}) begin
               state_in = S_REBASE;
            end else if (count_ff[ins_vc_ff] != '0) begin
               new_stamp_in = vt_ff + TIME_W'(spacing_ff[ins_vc_ff]);
               state_in     = S_SEEK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_REBASE: begin
            if (pos_ff < len_ff) begin
               list_stamp_in[idx] = (idx_stamp >= vt_ff) ? idx_stamp - vt_ff : '0;
               pos_in             = pos_ff + 1'b1;
            end else begin
               vt_in  = '0;
               pos_in = '0;
               if (count_ff[ins_vc_ff] != '0) begin
                  new_stamp_in = TIME_W'(spacing_ff[ins_vc_ff]);
                  state_in     = S_SEEK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SEEK: begin
            if ((pos_ff < len_ff) && (idx_stamp <= new_stamp_ff)) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               for (int i = 1; i < NUM_VC; i++) begin
                  if ((LEN_W'(i) > pos_ff) && (LEN_W'(i) <= len_ff)) begin
                     list_vc_in[i]    = list_vc_ff[i-1];
                     list_stamp_in[i] = list_stamp_ff[i-1];
                  end
               end
               list_vc_in[idx]    = ins_vc_ff;
               list_stamp_in[idx] = new_stamp_ff;
               len_in             = len_ff + 1'b1;
               state_in           = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_vc_in      = res_vc_ff;
               rsp_payload_in = res_payload_ff;
               rsp_qlen_in    = res_qlen_ff;
               rsp_time_in    = vt_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         limit_ff      <= LIMIT_RESET;
         vt_ff         <= '0;
         len_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_VC; i++) begin
            registered_ff[i] <= 1'b0;
            count_ff[i]      <= '0;
            head_ff[i]       <= '0;
            tail_ff[i]       <= '0;
         end
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         vt_ff         <= vt_in;
         len_ff        <= len_in;
         rsp_valid_ff  <= rsp_valid_in;
         registered_ff <= registered_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      item_ff        <= item_in;
      ins_vc_ff      <= ins_vc_in;
      new_stamp_ff   <= new_stamp_in;
      spacing_ff     <= spacing_in;
      capacity_ff    <= capacity_in;
      list_vc_ff     <= list_vc_in;
      list_stamp_ff  <= list_stamp_in;
      res_status_ff  <= res_status_in;
      res_vc_ff      <= res_vc_in;
      res_payload_ff <= res_payload_in;
      res_qlen_ff    <= res_qlen_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_vc_ff      <= rsp_vc_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_qlen_ff    <= rsp_qlen_in;
      rsp_time_ff    <= rsp_time_in;
   end

   // cell memory, registered read
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= item_ff.payload;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_sent_vc      = rsp_vc_ff;
   assign rsp_sent_payload = rsp_payload_ff;
   assign rsp_queue_length = QLEN_W'(rsp_qlen_ff);
   assign rsp_spacing_time = rsp_time_ff;

   `VS_ASSERT_NEXT(a_rebase_clears_time, clock, reset, (state_ff == S_REBASE) && (pos_ff >= len_ff), vt_ff == '0)
   `VS_ASSERT_IMPLIES(a_seek_has_room, clock, reset, state_ff == S_SEEK, len_ff < LEN_W'(NUM_VC))
   `VS_ASSERT_NEXT(a_done_loads_rsp, clock, reset, (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == S_IDLE))

endmodule

[hdl/virtual_spacing_wfq_scheduler_core.sv]
// top level of the virtual spacing wfq cell scheduler
// depends on vswfq_pkg, vswfq_front, vswfq_queue and vswfq_back
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  command, vc, payload, delta, buffer_limit
//   rsp       out        rsp_valid / rsp_ready  status, sent_vc, sent_payload, queue_length,
//                                               spacing_time
//   csr       in         csr_wr_en              time_limit
//
// a transaction is registered in the two-entry queue, then the engine pops it, executes it and
// loads the response; a first arrival also seeks its place in the ordered list, and a tick
// reads the sent cell, rebases the list when the spacing time passes the limit and re-inserts
// the connection if cells remain; the ordered list of len busy connections is walked one entry a cycle
// reset is synchronous and clears the registration flags, cell counts, pointers, the list length and the spacing time
// rsp stalls hold the engine in its final state; req stays ready while the queue has room
module virtual_spacing_wfq_scheduler_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [vswfq_pkg::CMD_W-1:0]      req_command,
   input  logic [vswfq_pkg::VCID_W-1:0]     req_vc,
   input  logic [vswfq_pkg::TAG_W-1:0]      req_payload,
   input  logic [vswfq_pkg::DELTA_W-1:0]    req_delta,
   input  logic [vswfq_pkg::BLIM_W-1:0]     req_buffer_limit,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [vswfq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [vswfq_pkg::SENT_VC_W-1:0]  rsp_sent_vc,
   output logic [vswfq_pkg::TAG_W-1:0]      rsp_sent_payload,
   output logic [vswfq_pkg::QLEN_W-1:0]     rsp_queue_length,
   output logic [vswfq_pkg::TIME_W-1:0]     rsp_spacing_time,
   input  logic                            csr_wr_en,
   input  logic [vswfq_pkg::LIMIT_W-1:0]    csr_wr_data
);
   import vswfq_pkg::*;

   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   vswfq_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_vc           (req_vc),
      .req_payload      (req_payload),
      .req_delta        (req_delta),
      .req_buffer_limit (req_buffer_limit),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_item      (q_push_item)
   );

   vswfq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_item  (q_item)
   );

   vswfq_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_sent_vc      (rsp_sent_vc),
      .rsp_sent_payload (rsp_sent_payload),
      .rsp_queue_length (rsp_queue_length),
      .rsp_spacing_time (rsp_spacing_time)
   );

endmodule

[tb/tb_virtual_spacing_wfq_scheduler_core.sv]
// self-checking testbench of the virtual spacing wfq cell scheduler
// holds its own scheduler predictor in a scoreboard class; plain tasks drive the block
// depends on vswfq_pkg and virtual_spacing_wfq_scheduler_core
`timescale 1ns / 1ps

module tb_virtual_spacing_wfq_scheduler_core;
   import vswfq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SENT_VC_W-1:0] sent_vc;
      logic [TAG_W-1:0]     sent_payload;
      logic [QLEN_W-1:0]    queue_length;
      logic [TIME_W-1:0]    spacing_time;
   } cell_result_t;

   class wfq_scoreboard;
      bit [LIMIT_W-1:0] time_limit;
      bit               vc_on[NUM_VC];
      bit [DELTA_W-1:0] spacing[NUM_VC];
      bit [BLIM_W-1:0]  capacity[NUM_VC];
      bit [QLEN_W-1:0]  count[NUM_VC];
      bit [TIME_W-1:0]  stamp[NUM_VC];
      bit [PTR_W-1:0]   head[NUM_VC];
      bit [PTR_W-1:0]   tail[NUM_VC];
      bit [TAG_W-1:0]   cells[NUM_VC*QUEUE_DEPTH];
      bit [VC_W-1:0]    order[NUM_VC];
      int               order_len;
      bit [TIME_W-1:0]  vtime;
      cell_result_t     expected_q[$];
      int               errors;

      function new();
         time_limit = LIMIT_RESET;
         order_len = 0;
         vtime = 0;
         errors = 0;
      endfunction

      function void schedule(int v);
         int pos;
         pos = 0;
         if (order_len >= NUM_VC) return;
         while (pos < order_len && stamp[order[pos]] <= stamp[v]) pos++;
         for (int i = order_len; i > pos; i--) order[i] = order[i-1];
         order[pos] = v;
         order_len++;
      endfunction

      function void note_request(bit [CMD_W-1:0] cmd, bit [VCID_W-1:0] vc,
                                 bit [TAG_W-1:0] pl, bit [DELTA_W-1:0] dl,
                                 bit [BLIM_W-1:0] bl);
         cell_result_t r;
         int v;
         r = '0;
         if (cmd == CMD_ARRIVAL) begin
            if (vc >= NUM_VC) r.status = ST_INVALID;
            else if (!vc_on[vc]) r.status = ST_UNREG;
            else begin
               if (count[vc] == 0) begin
                  stamp[vc] = vtime + spacing[vc];
                  schedule(vc);
               end
               if (count[vc] >= capacity[vc] || count[vc] >= QUEUE_DEPTH) r.status = ST_DROPPED;
               else begin
                  cells[vc*QUEUE_DEPTH + tail[vc]] = pl;
                  tail[vc] = tail[vc] + 1'b1;
                  count[vc] = count[vc] + 1'b1;
               end
               r.queue_length = count[vc];
            end
         end else if (cmd == CMD_TICK) begin
            if (order_len == 0) r.status = ST_EMPTY;
            else begin
               v = order[0];
               for (int i = 1; i < order_len; i++) order[i-1] = order[i];
               order_len--;
               vtime = stamp[v];
               r.sent_vc = SENT_VC_W'(v);
               r.sent_payload = cells[v*QUEUE_DEPTH + head[v]];
               head[v] = head[v] + 1'b1;
               if (count[v] > 0) count[v] = count[v] - 1'b1;
               if (vtime > time_limit) begin
                  for (int i = 0; i < NUM_VC; i++)
                     if (vc_on[i] && count[i] != 0)
                        stamp[i] = (stamp[i] >= vtime) ? stamp[i] - vtime : '0;
                  vtime = 0;
               end
               if (count[v] > 0) begin
                  stamp[v] = vtime + spacing[v];
                  schedule(v);
               end
               r.queue_length = count[v];
            end
         end else if (cmd == CMD_REGISTER) begin
            if (vc >= NUM_VC) r.status = ST_INVALID;
            else if (vc_on[vc] || dl == 0 || bl == 0 || bl > QUEUE_DEPTH) begin
               r.status = ST_BAD_REG;
               r.queue_length = count[vc];
            end else begin
               vc_on[vc] = 1;
               spacing[vc] = dl;
               capacity[vc] = bl;
               count[vc] = 0;
               head[vc] = 0;
               tail[vc] = 0;
            end
         end
         r.spacing_time = vtime;
         expected_q.push_back(r);
      endfunction

      function void check_response(cell_result_t got);
         cell_result_t e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.sent_vc !== e.sent_vc) begin
            $display("%0t: sent_vc expected %0d actual %0d", $time, e.sent_vc, got.sent_vc);
            errors++;
         end
         if (got.sent_payload !== e.sent_payload) begin
            $display("%0t: sent_payload expected %h actual %h", $time, e.sent_payload,
                     got.sent_payload);
            errors++;
         end
         if (got.queue_length !== e.queue_length) begin
            $display("%0t: queue_length expected %0d actual %0d", $time, e.queue_length,
                     got.queue_length);
            errors++;
         end
         if (got.spacing_time !== e.spacing_time) begin
            $display("%0t: spacing_time expected %0d actual %0d", $time, e.spacing_time,
                     got.spacing_time);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command;
   logic [VCID_W-1:0]    req_vc;
   logic [TAG_W-1:0]     req_payload;
   logic [DELTA_W-1:0]   req_delta;
   logic [BLIM_W-1:0]    req_buffer_limit;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SENT_VC_W-1:0] rsp_sent_vc;
   logic [TAG_W-1:0]     rsp_sent_payload;
   logic [QLEN_W-1:0]    rsp_queue_length;
   logic [TIME_W-1:0]    rsp_spacing_time;
   logic                 csr_wr_en;
   logic [LIMIT_W-1:0]   csr_wr_data;

   wfq_scoreboard sb;
   bit            calm;
   bit            hold_request;
   int            idle_cycles;

   virtual_spacing_wfq_scheduler_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_vc(req_vc), .req_payload(req_payload),
      .req_delta(req_delta), .req_buffer_limit(req_buffer_limit),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_sent_vc(rsp_sent_vc),
      .rsp_sent_payload(rsp_sent_payload), .rsp_queue_length(rsp_queue_length),
      .rsp_spacing_time(rsp_spacing_time),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // receiver with random stalls and one long hold-off
   initial begin
      int stall;
      int r;
      stall = 0;
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_status, rsp_sent_vc, rsp_sent_payload,
                               rsp_queue_length, rsp_spacing_time});
         if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else if (hold_request) begin
            hold_request = 0;
            stall = 400;
            rsp_ready <= 0;
         end else if (calm) begin
            rsp_ready <= 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               stall = (r < 2) ? $urandom_range(20, 80) : $urandom_range(0, 3);
               rsp_ready <= 0;
            end else begin
               rsp_ready <= 1;
            end
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send(input bit [CMD_W-1:0] c, input bit [VCID_W-1:0] v,
                       input bit [TAG_W-1:0] p, input bit [DELTA_W-1:0] d,
                       input bit [BLIM_W-1:0] b);
      int r;
      r = $urandom_range(0, 99);
      if (!calm && r < 25) begin
         req_valid <= 0;
         repeat ((r < 3) ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= c;
      req_vc <= v;
      req_payload <= p;
      req_delta <= d;
      req_buffer_limit <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_request(c, v, p, d, b);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_limit(input bit [LIMIT_W-1:0] value);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.time_limit = value;
   endtask

   function automatic int pick_vc(input bit want_on);
      int cand[$];
      for (int i = 0; i < NUM_VC; i++) if (sb.vc_on[i] == want_on) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   task automatic random_item(input int arrival_pct);
      int r;
      int v;
      bit [DELTA_W-1:0] d;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         case ($urandom_range(0, 4))
            0: send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
            1: send(CMD_ARRIVAL, $urandom_range(16, 255), $urandom, $urandom, $urandom);
            2: send(CMD_REGISTER, $urandom_range(16, 255), $urandom, $urandom, $urandom);
            3: send(CMD_REGISTER, $urandom_range(0, 15), $urandom, $urandom, $urandom);
            default: begin
               v = pick_vc(0);
               send(CMD_ARRIVAL, (v < 0) ? $urandom_range(0, 255) : v, $urandom,
                    $urandom, $urandom);
            end
         endcase
         return;
      end
      v = pick_vc(0);
      if (v >= 0 && (r < 14 || pick_vc(1) < 0)) begin
         d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 20);
         send(CMD_REGISTER, v, $urandom, d, $urandom_range(1, QUEUE_DEPTH));
      end else if (r < 14 + arrival_pct * 86 / 100) begin
         send(CMD_ARRIVAL, pick_vc(1), $urandom, $urandom, $urandom);
      end else begin
         send(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      bit [LIMIT_W-1:0] limits[5];
      int arrival_mix[5];
      sb = new();
      calm = 0;
      hold_request = 0;
      reset = 1;
      req_valid = 0;
      req_command = CMD_ARRIVAL;
      req_vc = 0;
      req_payload = 0;
      req_delta = 0;
      req_buffer_limit = 0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed part with a time limit of 1, so every tick that reaches a spacing time above 1 rebases
      write_limit(1);
      send(CMD_TICK, 0, 0, 0, 0);
      send(CMD_ARRIVAL, 5, 16'h1234, 0, 0);
      send(CMD_ARRIVAL, 200, 0, 0, 0);
      send(CMD_REGISTER, 16, 0, 1, 1);
      send(CMD_REGISTER, 255, 16'hffff, 16'hffff, 5'd31);
      send(CMD_REGISTER, 0, 0, 0, 4);
      send(CMD_REGISTER, 0, 0, 4, 0);
      send(CMD_REGISTER, 0, 0, 4, 17);
      send(CMD_REGISTER, 0, 0, 4, 5'd31);
      send(CMD_REGISTER, 0, 0, 1, 1);
      send(CMD_REGISTER, 15, 0, 16'hffff, QUEUE_DEPTH);
      send(CMD_REGISTER, 0, 0, 3, 3);
      send(CMD_ARRIVAL, 0, 16'h0000, 0, 0);
      send(CMD_ARRIVAL, 0, 16'hffff, 0, 0);
      send(CMD_ARRIVAL, 15, 16'hffff, 0, 0);
      send(CMD_ARRIVAL, 15, 16'h5a5a, 0, 0);
      send(CMD_UNUSED, 8'hff, 16'hffff, 16'hffff, 5'd31);
      send(CMD_TICK, 0, 0, 0, 0);
      send(CMD_TICK, 0, 0, 0, 0);
      send(CMD_TICK, 0, 0, 0, 0);
      send(CMD_TICK, 0, 0, 0, 0);
      send(CMD_ARRIVAL, 0, 16'habcd, 0, 0);
      send(CMD_TICK, 0, 0, 0, 0);
      drain();

      limits = '{31'h7fffffff, 50, $urandom_range(100, 5000), LIMIT_RESET, 1};
      arrival_mix = '{60, 45, 70, 50, 55};
      for (int ph = 0; ph < 5; ph++) begin
         write_limit(limits[ph]);
         calm = (ph == 3);
         for (int n = 0; n < 320; n++) begin
            if (ph == 1 && n == 100) hold_request = 1;
            if (ph == 2 && n == 160) begin
               req_valid <= 0;
               while (sb.expected_q.size() != 0) @(posedge clock);
            end
            random_item(arrival_mix[ph]);
         end
         drain();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+hdl
hdl/vswfq_pkg.sv
hdl/vswfq_front.sv
hdl/vswfq_queue.sv
hdl/vswfq_back.sv
hdl/virtual_spacing_wfq_scheduler_core.sv
tb/tb_virtual_spacing_wfq_scheduler_core.sv
